@@ hw/rtl/multi_list_sorted_queue_defines.svh @@
// Assertion macros for the sorted queue top module.
`ifndef MULTI_LIST_SORTED_QUEUE_DEFINES_SVH
`define MULTI_LIST_SORTED_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define MLSQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlsq assertion failed");
`define MLSQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlsq assertion failed");
`else
`define MLSQ_ASSERT_SAME(label, ante, cons)
`define MLSQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hw/rtl/mlsq_pkg.sv @@
package mlsq_pkg;

    // Request kinds
    typedef enum logic [2:0] {
        REQ_INSERT  = 3'd0,
        REQ_FIND    = 3'd1,
        REQ_DELETE  = 3'd2,
        REQ_REMMIN  = 3'd3,
        REQ_DESTROY = 3'd4
    } req_t;

    // Result status codes
    typedef enum logic [2:0] {
        STS_DONE      = 3'd0,
        STS_FOUND     = 3'd1,
        STS_NOT_FOUND = 3'd2,
        STS_INVALID   = 3'd3,
        STS_EMPTY     = 3'd4,
        STS_NOT_EMPTY = 3'd5,
        STS_FULL      = 3'd6
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHK,
        ST_LINK,
        ST_WPREV,
        ST_RESP
    } state_t;

    // Configuration register indexes
    localparam logic CFG_MAX_LISTS     = 1'b0;
    localparam logic CFG_LISTS_CREATED = 1'b1;

    localparam int KEY_W  = 64;
    localparam int DATA_W = 64;

    // List table and used-map update controls
    typedef struct packed {
        logic head_we;
        logic len_inc;
        logic len_dec;
        logic used_set;
        logic used_clr;
    } upd_t;

endpackage

@@ hw/rtl/mlsq_ram.sv @@
module mlsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/mlsq_lists.sv @@
module mlsq_lists
    import mlsq_pkg::*;
#(
    parameter int NUM_LISTS     = 16,
    parameter int STORE_ENTRIES = 256
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [(NUM_LISTS > 1 ? $clog2(NUM_LISTS) : 1)-1:0] rd_idx,
    output logic [$clog2(STORE_ENTRIES)-1:0]       head_rd,
    output logic [$clog2(STORE_ENTRIES):0]         len_rd,
    input  logic [(NUM_LISTS > 1 ? $clog2(NUM_LISTS) : 1)-1:0] upd_idx,
    input  upd_t                                   upd,
    input  logic [$clog2(STORE_ENTRIES)-1:0]       head_val,
    input  logic [$clog2(STORE_ENTRIES)-1:0]       used_idx,
    input  logic [$clog2(STORE_ENTRIES)-1:0]       scan_idx,
    output logic                                   scan_used,
    output logic                                   full,
    output logic                                   clearing
);

    localparam int EW   = $clog2(STORE_ENTRIES);
    localparam int LENW = EW + 1;

    logic [EW-1:0]   head_reg [NUM_LISTS];
    logic [LENW-1:0] len_reg  [NUM_LISTS];
    logic [LENW-1:0] count_reg;
    logic            clr_busy_reg;
    logic [EW-1:0]   clr_idx_reg;
    logic            used_we;
    logic [EW-1:0]   used_waddr;
    logic            used_wdata;

    assign head_rd  = head_reg[rd_idx];
    assign len_rd   = len_reg[rd_idx];
    assign full     = (count_reg >= LENW'(STORE_ENTRIES));
    assign clearing = clr_busy_reg;

    // Drive the used-map write port: clearing pass first, then request updates
    assign used_we    = clr_busy_reg || upd.used_set || upd.used_clr;
    assign used_waddr = clr_busy_reg ? clr_idx_reg : used_idx;
    assign used_wdata = !clr_busy_reg && upd.used_set;

    // Used map; its registered read gives the bit in the cycle after the scan address is presented
    mlsq_ram #(
        .WIDTH (1),
        .DEPTH (STORE_ENTRIES)
    ) u_used_ram (
        .clk   (clk),
        .we    (used_we),
        .waddr (used_waddr),
        .wdata (used_wdata),
        .re    (1'b1),
        .raddr (scan_idx),
        .rdata (scan_used)
    );

    // Clear the used map one entry per cycle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + EW'(1);
            if (clr_idx_reg == EW'(STORE_ENTRIES - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Hold list heads
    always_ff @(posedge clk)
    begin
        if (upd.head_we)
        begin
            head_reg[upd_idx] <= head_val;
        end
    end

    // Track list lengths and the used count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                len_reg[i] <= '0;
            end
            count_reg <= '0;
        end
        else
        begin
            if (upd.len_inc)
            begin
                len_reg[upd_idx] <= len_reg[upd_idx] + LENW'(1);
            end
            else if (upd.len_dec)
            begin
                len_reg[upd_idx] <= len_reg[upd_idx] - LENW'(1);
            end
            if (upd.used_set)
            begin
                count_reg <= count_reg + LENW'(1);
            end
            else if (upd.used_clr)
            begin
                if (count_reg != '0)
                begin
                    count_reg <= count_reg - LENW'(1);
                end
            end
        end
    end

endmodule

@@ hw/rtl/multi_list_sorted_queue.sv @@
// Sorted multi-list queue: up to NUM_LISTS ascending-key linked lists share
// one entry store of STORE_ENTRIES entries kept in a single-port-read RAM;
// the used-entry map sits in a second, one-bit RAM.
// Input channel s_*: one request per item, kind in s_tuser, list index, key
// and payload in s_tdata. Output channel m_*: exactly one result per
// request, status in m_tuser, key and data in m_tdata.
// Configuration: cfg_we/cfg_addr/cfg_wdata write max_lists (0) and
// lists_created (1); write only while no request is in flight.
// Invalid, unknown, destroy-check and empty-list requests and inserts into a
// full store go straight to the result. Remove-min reads the head entry and
// pops it. Find and delete read the list entry by entry from its head until
// a payload match or its end. Insert scans the used map one entry per cycle
// for the lowest free entry, walks the list past each entry whose key is not
// larger, writes the new entry, then rewrites its predecessor if it has one.
// One request is worked at a time; the next is accepted in the cycle after the
// result is loaded. Reset clears list lengths and the used count at once,
// then clears the used map entry by entry with s_tready low.
// When the receiver stalls, the result waits in the output register and the
// block may accept and work one more request; it then holds that result
// until the output register frees.
`include "multi_list_sorted_queue_defines.svh"

module multi_list_sorted_queue
    import mlsq_pkg::*;
#(
    parameter int NUM_LISTS     = 16,
    parameter int STORE_ENTRIES = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [2:0]   s_tuser,   // req_type
    input  logic [135:0] s_tdata,   // list_index, key, payload, pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [2:0]   m_tuser,   // status
    output logic [127:0] m_tdata,   // key_out, data_out
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [4:0]   cfg_wdata
);

    localparam int EW   = $clog2(STORE_ENTRIES);
    localparam int LENW = EW + 1;
    localparam int LIW  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int RW   = KEY_W + DATA_W + EW;

    // Input field split
    logic [3:0]        in_li;
    logic [KEY_W-1:0]  in_key;
    logic [DATA_W-1:0] in_data;
    assign in_li   = s_tdata[3:0];
    assign in_key  = s_tdata[67:4];
    assign in_data = s_tdata[131:68];

    // Configuration registers
    logic [4:0] max_lists_reg;
    logic [4:0] lists_created_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_lists_reg     <= 5'd16;
            lists_created_reg <= 5'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MAX_LISTS:     max_lists_reg     <= cfg_wdata;
                CFG_LISTS_CREATED: lists_created_reg <= cfg_wdata;
                default:           max_lists_reg     <= max_lists_reg;
            endcase
        end
    end

    // Control and request registers
    state_t             state_reg, state_next;
    logic [2:0]         req_reg, req_next;
    logic [LIW-1:0]     li_reg, li_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [DATA_W-1:0]  data_reg, data_next;
    logic [EW-1:0]      head_reg, head_next;
    logic [LENW-1:0]    len_reg, len_next;
    logic [LENW-1:0]    n_reg, n_next;
    logic [EW-1:0]      cur_reg, cur_next;
    logic [EW-1:0]      prev_reg, prev_next;
    logic               have_prev_reg, have_prev_next;
    logic [KEY_W-1:0]   prev_key_reg, prev_key_next;
    logic [DATA_W-1:0]  prev_data_reg, prev_data_next;
    logic [EW-1:0]      slot_reg, slot_next;
    status_t            res_status_reg, res_status_next;
    logic [KEY_W-1:0]   res_key_reg, res_key_next;
    logic [DATA_W-1:0]  res_data_reg, res_data_next;

    // Output register
    logic               out_valid_reg;
    logic [2:0]         out_status_reg;
    logic [KEY_W-1:0]   out_key_reg;
    logic [DATA_W-1:0]  out_data_reg;

    // Entry RAM and list table
    logic               ram_we, ram_re;
    logic [EW-1:0]      ram_waddr, ram_raddr;
    logic [RW-1:0]      ram_wdata, ram_rdata;
    logic [KEY_W-1:0]   m_key;
    logic [DATA_W-1:0]  m_data;
    logic [EW-1:0]      m_link;
    logic [EW-1:0]      head_rd;
    logic [LENW-1:0]    len_rd;
    upd_t               upd;
    logic [EW-1:0]      head_val, used_idx;
    logic               scan_used, full;
    logic               clearing;
    logic               li_ok;

    assign m_key  = ram_rdata[KEY_W-1:0];
    assign m_data = ram_rdata[KEY_W +: DATA_W];
    assign m_link = ram_rdata[KEY_W + DATA_W +: EW];

    assign li_ok = ({1'b0, in_li} < lists_created_reg) && ({1'b0, in_li} < max_lists_reg)
                   && (32'(in_li) < NUM_LISTS);

    mlsq_ram #(
        .WIDTH (RW),
        .DEPTH (STORE_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mlsq_lists #(
        .NUM_LISTS     (NUM_LISTS),
        .STORE_ENTRIES (STORE_ENTRIES)
    ) u_lists (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_idx    (LIW'(in_li)),
        .head_rd   (head_rd),
        .len_rd    (len_rd),
        .upd_idx   (li_reg),
        .upd       (upd),
        .head_val  (head_val),
        .used_idx  (used_idx),
        .scan_idx  (slot_next),
        .scan_used (scan_used),
        .full      (full),
        .clearing  (clearing)
    );

    assign s_tready = (state_reg == ST_IDLE) && !clearing;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_data_reg, out_key_reg};

    // Next state, RAM access and list table updates
    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        li_next         = li_reg;
        key_next        = key_reg;
        data_next       = data_reg;
        head_next       = head_reg;
        len_next        = len_reg;
        n_next          = n_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        have_prev_next  = have_prev_reg;
        prev_key_next   = prev_key_reg;
        prev_data_next  = prev_data_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_data_next   = res_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = slot_reg;
        ram_wdata       = {slot_reg, prev_data_reg, prev_key_reg};
        ram_re          = 1'b0;
        ram_raddr       = cur_reg;
        upd             = '0;
        head_val        = slot_reg;
        used_idx        = cur_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    req_next        = s_tuser;
                    li_next         = LIW'(in_li);
                    key_next        = in_key;
                    data_next       = in_data;
                    head_next       = head_rd;
                    len_next        = len_rd;
                    n_next          = len_rd;
                    cur_next        = head_rd;
                    have_prev_next  = 1'b0;
                    slot_next       = '0;
                    res_key_next    = '0;
                    res_data_next   = '0;
                    res_status_next = STS_DONE;
                    state_next      = ST_RESP;
                    if (s_tuser > REQ_DESTROY)
                    begin
                        res_status_next = STS_DONE;
                    end
                    else if (!li_ok)
                    begin
                        res_status_next = STS_INVALID;
                    end
                    else
                    begin
                        case (s_tuser)
                            REQ_INSERT:
                            begin
                                if (full)
                                begin
                                    res_status_next = STS_FULL;
                                end
                                else
                                begin
                                    state_next = ST_SCAN;
                                end
                            end
                            REQ_FIND, REQ_DELETE:
                            begin
                                if (len_rd == '0)
                                begin
                                    res_status_next = STS_NOT_FOUND;
                                end
                                else
                                begin
                                    ram_re     = 1'b1;
                                    ram_raddr  = head_rd;
                                    state_next = ST_CHK;
                                end
                            end
                            REQ_REMMIN:
                            begin
                                if (len_rd == '0)
                                begin
                                    res_status_next = STS_EMPTY;
                                end
                                else
                                begin
                                    ram_re     = 1'b1;
                                    ram_raddr  = head_rd;
                                    state_next = ST_CHK;
                                end
                            end
                            default:
                            begin
                                res_status_next = (len_rd != '0) ? STS_NOT_EMPTY : STS_DONE;
                            end
                        endcase
                    end
                end
            end

            // Find the lowest free entry, then start the walk; the used bit
            // in hand belongs to the entry addressed in the previous cycle
            ST_SCAN:
            begin
                if (!scan_used)
                begin
                    if (len_reg == '0)
                    begin
                        state_next = ST_LINK;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = head_reg;
                        state_next = ST_CHK;
                    end
                end
                else
                begin
                    slot_next = slot_reg + EW'(1);
                end
            end

            // Examine the entry read in the previous cycle
            ST_CHK:
            begin
                case (req_reg)
                    REQ_INSERT:
                    begin
                        if (m_key <= key_reg)
                        begin
                            prev_next      = cur_reg;
                            have_prev_next = 1'b1;
                            prev_key_next  = m_key;
                            prev_data_next = m_data;
                            cur_next       = m_link;
                            n_next         = n_reg - LENW'(1);
                            if (n_next == '0)
                            begin
                                state_next = ST_LINK;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = m_link;
                            end
                        end
                        else
                        begin
                            state_next = ST_LINK;
                        end
                    end
                    REQ_FIND, REQ_DELETE:
                    begin
                        if (m_data == data_reg)
                        begin
                            state_next = ST_RESP;
                            if (req_reg == REQ_FIND)
                            begin
                                res_status_next = STS_FOUND;
                                res_key_next    = m_key;
                            end
                            else
                            begin
                                res_status_next = STS_DONE;
                                upd.len_dec     = 1'b1;
                                upd.used_clr    = 1'b1;
                                if (have_prev_reg)
                                begin
                                    ram_we    = 1'b1;
                                    ram_waddr = prev_reg;
                                    ram_wdata = {m_link, prev_data_reg, prev_key_reg};
                                end
                                else
                                begin
                                    upd.head_we = 1'b1;
                                    head_val    = m_link;
                                end
                            end
                        end
                        else
                        begin
                            prev_next      = cur_reg;
                            have_prev_next = 1'b1;
                            prev_key_next  = m_key;
                            prev_data_next = m_data;
                            cur_next       = m_link;
                            n_next         = n_reg - LENW'(1);
                            if (n_next == '0)
                            begin
                                res_status_next = STS_NOT_FOUND;
                                state_next      = ST_RESP;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = m_link;
                            end
                        end
                    end
                    default:
                    begin
                        // Pop the head entry
                        upd.head_we     = 1'b1;
                        head_val        = m_link;
                        upd.len_dec     = 1'b1;
                        upd.used_clr    = 1'b1;
                        res_status_next = STS_FOUND;
                        res_key_next    = m_key;
                        res_data_next   = m_data;
                        state_next      = ST_RESP;
                    end
                endcase
            end

            // Write the new entry and claim its slot
            ST_LINK:
            begin
                ram_we          = 1'b1;
                ram_waddr       = slot_reg;
                ram_wdata       = {((n_reg != '0) ? cur_reg : EW'(0)), data_reg, key_reg};
                upd.len_inc     = 1'b1;
                upd.used_set    = 1'b1;
                used_idx        = slot_reg;
                res_status_next = STS_DONE;
                if (have_prev_reg)
                begin
                    state_next = ST_WPREV;
                end
                else
                begin
                    upd.head_we = 1'b1;
                    head_val    = slot_reg;
                    state_next  = ST_RESP;
                end
            end

            // Point the predecessor at the new entry
            ST_WPREV:
            begin
                ram_we     = 1'b1;
                ram_waddr  = prev_reg;
                ram_wdata  = {slot_reg, prev_data_reg, prev_key_reg};
                state_next = ST_RESP;
            end

            // Hand the result to the output register
            ST_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_RESP && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        li_reg         <= li_next;
        key_reg        <= key_next;
        data_reg       <= data_next;
        head_reg       <= head_next;
        len_reg        <= len_next;
        n_reg          <= n_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        have_prev_reg  <= have_prev_next;
        prev_key_reg   <= prev_key_next;
        prev_data_reg  <= prev_data_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_data_reg   <= res_data_next;
        if (state_reg == ST_RESP && (!out_valid_reg || m_tready))
        begin
            out_status_reg <= res_status_reg;
            out_key_reg    <= res_key_reg;
            out_data_reg   <= res_data_reg;
        end
    end

    `MLSQ_ASSERT_SAME(a_ram_we_state, ram_we, (state_reg == ST_LINK) || (state_reg == ST_WPREV) || (state_reg == ST_CHK))
    `MLSQ_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, state_reg != ST_IDLE)
    `MLSQ_ASSERT_SAME(a_walk_in_range, state_reg == ST_CHK, n_reg != '0)

endmodule

@@ bench/multi_list_sorted_queue_checker.sv @@
`timescale 1ns / 1ps

module multi_list_sorted_queue_checker
    import mlsq_pkg::*;
(
    input  logic         clk,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [2:0]   s_tuser,   // req_type
    input  logic [135:0] s_tdata,   // list_index, key, payload, pad
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [2:0]   m_tuser,   // status
    input  logic [127:0] m_tdata,   // key_out, data_out
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [4:0]   cfg_wdata,
    output int           fail_count,
    output int           pending
);

    localparam int LISTS   = 16;
    localparam int ENTRIES = 256;

    typedef struct {
        status_t     status;
        logic [63:0] key_out;
        logic [63:0] data_out;
    } answer_t;

    // Shadow copy of the entry store and list table
    logic [63:0] shadow_key  [ENTRIES];
    logic [63:0] shadow_data [ENTRIES];
    int          shadow_link [ENTRIES];
    bit          shadow_used [ENTRIES];
    int          shadow_head [LISTS];
    int          shadow_len  [LISTS];
    int          used_total;
    logic [4:0]  max_lists;
    logic [4:0]  lists_created;

    answer_t answer_queue[$];

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_key[i]  = '0;
            shadow_data[i] = '0;
            shadow_link[i] = 0;
            shadow_used[i] = 0;
        end
        for (int i = 0; i < LISTS; i++)
        begin
            shadow_head[i] = 0;
            shadow_len[i]  = 0;
        end
        used_total    = 0;
        max_lists     = 5'd16;
        lists_created = 5'd1;
        fail_count    = 0;
    end

    // Work out the answer to one request and update the shadow lists
    function automatic answer_t sorted_list_answer(logic [2:0] rq, logic [3:0] li,
                                                   logic [63:0] k, logic [63:0] d);
        answer_t a;
        int      len;
        int      cur;
        int      prev;
        int      n;
        int      slot;
        bit      have_prev;
        bit      hit;
        a.status   = STS_DONE;
        a.key_out  = '0;
        a.data_out = '0;
        if (rq > REQ_DESTROY)
            return a;
        if (li >= lists_created || li >= max_lists)
        begin
            a.status = STS_INVALID;
            return a;
        end
        len = shadow_len[li];
        if (rq == REQ_INSERT)
        begin
            if (used_total >= ENTRIES)
            begin
                a.status = STS_FULL;
                return a;
            end
            slot = 0;
            while (slot < ENTRIES && shadow_used[slot])
                slot++;
            have_prev = 0;
            prev = 0;
            cur = shadow_head[li];
            n = len;
            while (n > 0 && shadow_key[cur] <= k)
            begin
                prev = cur;
                have_prev = 1;
                cur = shadow_link[cur];
                n--;
            end
            shadow_key[slot]  = k;
            shadow_data[slot] = d;
            shadow_link[slot] = (n > 0) ? cur : 0;
            shadow_used[slot] = 1;
            if (have_prev)
                shadow_link[prev] = slot;
            else
                shadow_head[li] = slot;
            shadow_len[li] = len + 1;
            used_total++;
        end
        else if (rq == REQ_FIND || rq == REQ_DELETE)
        begin
            have_prev = 0;
            hit = 0;
            prev = 0;
            cur = shadow_head[li];
            for (n = len; n > 0 && !hit; n--)
            begin
                if (shadow_data[cur] == d)
                    hit = 1;
                else
                begin
                    prev = cur;
                    have_prev = 1;
                    cur = shadow_link[cur];
                end
            end
            if (!hit)
                a.status = STS_NOT_FOUND;
            else if (rq == REQ_FIND)
            begin
                a.status  = STS_FOUND;
                a.key_out = shadow_key[cur];
            end
            else
            begin
                if (have_prev)
                    shadow_link[prev] = shadow_link[cur];
                else
                    shadow_head[li] = shadow_link[cur];
                shadow_used[cur] = 0;
                shadow_len[li] = len - 1;
                used_total--;
            end
        end
        else if (rq == REQ_REMMIN)
        begin
            if (len == 0)
                a.status = STS_EMPTY;
            else
            begin
                cur = shadow_head[li];
                shadow_head[li] = shadow_link[cur];
                shadow_len[li] = len - 1;
                shadow_used[cur] = 0;
                used_total--;
                a.status   = STS_FOUND;
                a.key_out  = shadow_key[cur];
                a.data_out = shadow_data[cur];
            end
        end
        else
            a.status = (len != 0) ? STS_NOT_EMPTY : STS_DONE;
        return a;
    endfunction

    always @(posedge clk)
    begin
        answer_t want;
        // Compare each result with the oldest expected answer
        if (m_tvalid && m_tready)
        begin
            if (answer_queue.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: status %0d key %h data %h",
                             m_tuser, m_tdata[63:0], m_tdata[127:64]);
            end
            else
            begin
                want = answer_queue.pop_front();
                if (m_tuser != want.status || m_tdata[63:0] != want.key_out ||
                    m_tdata[127:64] != want.data_out)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected status %0d key %h data %h, got %0d %h %h",
                                 want.status, want.key_out, want.data_out,
                                 m_tuser, m_tdata[63:0], m_tdata[127:64]);
                end
            end
        end
        // Predict the answer to each accepted request
        if (s_tvalid && s_tready)
            answer_queue.push_back(sorted_list_answer(s_tuser, s_tdata[3:0],
                                                      s_tdata[67:4], s_tdata[131:68]));
        // Track register writes
        if (cfg_we)
        begin
            if (cfg_addr == CFG_MAX_LISTS)
                max_lists = cfg_wdata;
            else
                lists_created = cfg_wdata;
        end
        pending <= answer_queue.size();
    end

endmodule

@@ bench/multi_list_sorted_queue_tb.sv @@
`timescale 1ns / 1ps

module multi_list_sorted_queue_tb;
    import mlsq_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [2:0]   s_tuser = '0;     // req_type
    logic [135:0] s_tdata = '0;     // list_index, key, payload, pad
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [2:0]   m_tuser;          // status
    logic [127:0] m_tdata;          // key_out, data_out
    logic         cfg_we = 1'b0;
    logic         cfg_addr = 1'b0;
    logic [4:0]   cfg_wdata = '0;

    int fail_count;
    int pending;
    bit quiet = 0;
    int idle_cycles = 0;
    int top_list = 0;
    int insert_weight = 35;

    multi_list_sorted_queue DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    multi_list_sorted_queue_checker checker_i (
        .clk(clk),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Receiver side: stall in random bursts unless in the quiet tail
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // Watchdog on cycles with no accepted request or result
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("multi_list_sorted_queue test failed");
            $finish;
        end
    end

    // Send one request and hold it until accepted
    task automatic send_req(logic [2:0] rq, logic [3:0] li, logic [63:0] k, logic [63:0] d);
        s_tuser  <= rq;
        s_tdata  <= {4'b0, d, k, li};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // Hold off until every answer has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limits(logic [4:0] lists_max, logic [4:0] created);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_MAX_LISTS;
        cfg_wdata <= lists_max;
        @(posedge clk);
        cfg_addr  <= CFG_LISTS_CREATED;
        cfg_wdata <= created;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random request mix; small key and data pools make hits and ties common
    task automatic random_req();
        int          pick;
        logic [2:0]  rq;
        logic [3:0]  li;
        logic [63:0] k;
        logic [63:0] d;
        pick = $urandom_range(0, 99);
        if (pick < insert_weight)
            rq = REQ_INSERT;
        else if (pick < insert_weight + 15)
            rq = REQ_FIND;
        else if (pick < insert_weight + 35)
            rq = REQ_DELETE;
        else if (pick < insert_weight + 50)
            rq = REQ_REMMIN;
        else if (pick < insert_weight + 58)
            rq = REQ_DESTROY;
        else
            rq = 3'($urandom_range(5, 7));
        li = ($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'($urandom_range(0, top_list));
        k = ($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 15)) : {$urandom, $urandom};
        d = ($urandom_range(0, 9) < 7) ? 64'($urandom_range(0, 31)) : {$urandom, $urandom};
        send_req(rq, li, k, d);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset limits: list 0 valid only
        send_req(REQ_DESTROY, 4'd0, 64'd0, 64'd0);
        send_req(REQ_REMMIN, 4'd0, 64'd0, 64'd0);
        send_req(REQ_INSERT, 4'd0, '1, '1);
        send_req(REQ_INSERT, 4'd0, 64'd0, 64'd0);
        send_req(REQ_INSERT, 4'd0, 64'd5, 64'hA);
        send_req(REQ_INSERT, 4'd0, 64'd5, 64'hB);
        send_req(REQ_FIND, 4'd0, 64'd0, 64'hB);
        send_req(REQ_FIND, 4'd0, 64'd0, 64'hC);
        send_req(REQ_FIND, 4'd0, 64'd0, '1);
        send_req(REQ_DELETE, 4'd0, 64'd0, 64'hA);
        send_req(REQ_DELETE, 4'd0, 64'd0, 64'hA);
        send_req(REQ_DESTROY, 4'd0, 64'd0, 64'd0);
        send_req(3'd5, 4'd0, 64'd0, 64'd0);
        send_req(3'd6, 4'd3, '1, '1);
        send_req(3'd7, 4'd15, 64'd0, 64'd0);
        send_req(REQ_INSERT, 4'd1, 64'd1, 64'd1);
        send_req(REQ_FIND, 4'd15, 64'd0, 64'd0);
        send_req(REQ_REMMIN, 4'd0, 64'd0, 64'd0);
        send_req(REQ_REMMIN, 4'd0, 64'd0, 64'd0);
        send_req(REQ_REMMIN, 4'd0, 64'd0, 64'd0);
        send_req(REQ_REMMIN, 4'd0, 64'd0, 64'd0);
        send_req(REQ_DESTROY, 4'd0, 64'd0, 64'd0);

        // All lists open
        write_limits(5'd16, 5'd16);
        top_list = 15;
        for (int i = 0; i < 500; i++)
        begin
            random_req();
            if (i == 250)
                drain();
        end

        // Few lists, mostly inserts: fill the shared store
        write_limits(5'd16, 5'd4);
        top_list = 4;
        insert_weight = 90;
        for (int i = 0; i < 320; i++)
            random_req();
        insert_weight = 10;
        for (int i = 0; i < 100; i++)
            random_req();

        // Zero limits: every request of a known kind is rejected as invalid
        write_limits(5'd0, 5'd16);
        for (int i = 0; i < 40; i++)
            random_req();
        write_limits(5'd16, 5'd0);
        for (int i = 0; i < 40; i++)
            random_req();

        // Limit above the list count
        write_limits(5'd31, 5'd31);
        top_list = 15;
        insert_weight = 35;
        for (int i = 0; i < 150; i++)
            random_req();

        // Tail without idling
        write_limits(5'd8, 5'd16);
        quiet = 1;
        for (int i = 0; i < 250; i++)
            random_req();

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("multi_list_sorted_queue test passed");
        else
            $display("multi_list_sorted_queue test failed");
        $finish;
    end

endmodule

@@ multi_list_sorted_queue.f @@
+incdir+hw/rtl
hw/rtl/mlsq_pkg.sv
hw/rtl/mlsq_ram.sv
hw/rtl/mlsq_lists.sv
hw/rtl/multi_list_sorted_queue.sv
bench/multi_list_sorted_queue_checker.sv
bench/multi_list_sorted_queue_tb.sv
